### hw/rtl/xer_pkg.sv
// ----------------------------------------------------------------------------
// xer_pkg
// shared constants, entity table and control types of the entity decoder
// ----------------------------------------------------------------------------
package xer_pkg;

    localparam int SCAN_WINDOW = 12;
    localparam int BUF_DEPTH   = SCAN_WINDOW;
    localparam int CNT_W       = $clog2(BUF_DEPTH + 1);
    localparam int IDX_W       = $clog2(BUF_DEPTH);
    localparam int CP_W        = 21;
    localparam int ACC_W       = CP_W + 4;
    localparam int ENT_NUM     = 30;
    localparam int NAME_MAX    = 6;

    localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    // emit byte select
    localparam logic [1:0] SEL_CUR     = 2'd0;
    localparam logic [1:0] SEL_AMP     = 2'd1;
    localparam logic [1:0] SEL_AMP_UNK = 2'd2;
    localparam logic [1:0] SEL_UTF     = 2'd3;

    typedef struct packed {
        logic       load;
        logic       drop;
        logic       hold;
        logic       amp_set;
        logic       amp_clr;
        logic       rewind;
        logic       emit;
        logic [1:0] emit_sel;
        logic       flush;
        logic       tab_load;
        logic       parse_start;
        logic       parse_step;
        logic       cp_num;
        logic       utf_step;
    } cmd_t;

    typedef struct packed {
        logic have_byte;
        logic is_amp;
        logic is_semi;
        logic window_full;
        logic amp_open;
        logic last;
        logic tab_hit;
        logic numeric;
        logic parse_more;
        logic parse_ok;
        logic utf_final;
        logic can_emit;
        logic can_flush;
    } sts_t;

    localparam logic [8*NAME_MAX-1:0] ENT_NAME [ENT_NUM] = '{
        "lt", "gt", "amp", "quot", "apos", "nbsp", "copy", "reg", "trade", "hellip",
        "ndash", "mdash", "lsquo", "rsquo", "ldquo", "rdquo", "laquo", "raquo",
        "middot", "bull", "sect", "para", "deg", "plusmn", "times", "divide",
        "euro", "pound", "yen", "cent"
    };

    localparam logic [2:0] ENT_LEN [ENT_NUM] = '{
        3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd5, 3'd6,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
        3'd6, 3'd4, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd6,
        3'd4, 3'd5, 3'd3, 3'd4
    };

    localparam logic [15:0] ENT_CP [ENT_NUM] = '{
        16'h003C, 16'h003E, 16'h0026, 16'h0022, 16'h0027, 16'h00A0, 16'h00A9,
        16'h00AE, 16'h2122, 16'h2026, 16'h2013, 16'h2014, 16'h2018, 16'h2019,
        16'h201C, 16'h201D, 16'h00AB, 16'h00BB, 16'h00B7, 16'h2022, 16'h00A7,
        16'h00B6, 16'h00B0, 16'h00B1, 16'h00D7, 16'h00F7, 16'h20AC, 16'h00A3,
        16'h00A5, 16'h00A2
    };

    // character j of entity name k, first character at j = 0
    function automatic logic [7:0] ent_byte(input int k, input int j);
        logic [8*NAME_MAX-1:0] w;
        w = ENT_NAME[k] << (8 * (NAME_MAX - int'(ENT_LEN[k])));
        return w[8*(NAME_MAX-1-j) +: 8];
    endfunction

endpackage

### hw/rtl/xml_entity_reference_decoder.sv
// ----------------------------------------------------------------------------
// xml_entity_reference_decoder
// streaming decoder of xml character and named entity references
// ----------------------------------------------------------------------------
// s_axis carries one raw byte per beat, tlast on the final byte of a value.
// m_axis carries decoded bytes, tlast on the final byte of a value, tuser set
// on the literal '&' of an unknown terminated reference in strict mode.
// cfg_valid/cfg_data writes strict mode (reset 1); cfg_ready is always high.
// one input beat is taken, then its bytes are processed one per cycle in the
// controller while the output has room; an ordinary byte passes accept, scan,
// end of window and hand-off.
// a ';' adds a lookup step, a parse step per numeric digit and a final check,
// and a step per utf-8 byte; a reference failed at lookup or parse adds a step
// for the literal '&', and a failed reference rescans up to 12 held bytes.
// an emitted byte waits in the pending stage and moves to the output register
// on the next emit or the flush; s_axis_tready stays low until every result of
// the beat is in the output stages. reset empties the window, closes any
// reference and clears both output stages; a stalled m_axis holds its beat and stops the scan on the next one.
// ----------------------------------------------------------------------------
module xml_entity_reference_decoder
    import xer_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser,   // unknown_entity
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data        // strict_entities
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    xer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    xer_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .out_tready (m_axis_tready),
        .out_tvalid (m_axis_tvalid),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .out_unk    (m_axis_tuser)
    );

endmodule

### hw/rtl/xer_ctrl.sv
// ----------------------------------------------------------------------------
// xer_ctrl
// sequencer of the entity decoder: scan, name lookup, numeric parse, emit
// ----------------------------------------------------------------------------
module xer_ctrl
    import xer_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_tvalid,
    output logic in_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_LOOKUP = 3'd2;
    localparam logic [2:0] ST_PARSE  = 3'd3;
    localparam logic [2:0] ST_FAIL   = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;
    localparam logic [2:0] ST_FLUSH  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.have_byte)
                begin
                    if (!sts.amp_open)
                    begin
                        if (sts.is_amp)
                        begin
                            cmd.amp_set = 1'b1;
                            cmd.drop    = 1'b1;
                        end
                        else if (sts.can_emit)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = SEL_CUR;
                            cmd.drop     = 1'b1;
                        end
                    end
                    else if (sts.is_semi)
                    begin
                        state_next = ST_LOOKUP;
                    end
                    else if (sts.window_full)
                    begin
                        if (sts.can_emit)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = SEL_AMP;
                            cmd.amp_clr  = 1'b1;
                            cmd.rewind   = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.hold = 1'b1;
                    end
                end
                else if (sts.last && sts.amp_open)
                begin
                    if (sts.can_emit)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = SEL_AMP;
                        cmd.amp_clr  = 1'b1;
                        cmd.rewind   = 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_LOOKUP:
            begin
                if (sts.tab_hit)
                begin
                    cmd.tab_load = 1'b1;
                    state_next   = ST_EMIT;
                end
                else if (sts.numeric)
                begin
                    cmd.parse_start = 1'b1;
                    state_next      = ST_PARSE;
                end
                else
                begin
                    state_next = ST_FAIL;
                end
            end
            ST_PARSE:
            begin
                if (sts.parse_more)
                begin
                    cmd.parse_step = 1'b1;
                end
                else if (sts.parse_ok)
                begin
                    cmd.cp_num = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_FAIL;
                end
            end
            ST_FAIL:
            begin
                if (sts.can_emit)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_AMP_UNK;
                    cmd.amp_clr  = 1'b1;
                    cmd.rewind   = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_EMIT:
            begin
                if (sts.can_emit)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_UTF;
                    cmd.utf_step = 1'b1;
                    if (sts.utf_final)
                    begin
                        cmd.drop    = 1'b1;
                        cmd.amp_clr = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (sts.can_flush)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_emit_only_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.can_emit)
        else $error("emit without room");

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == ST_IDLE && in_tvalid)
        else $error("load outside idle");

    a_flush_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> state_reg == ST_IDLE)
        else $error("flush did not return to idle");

endmodule

### hw/rtl/xer_dp.sv
// ----------------------------------------------------------------------------
// xer_dp
// datapath: byte window, entity match, numeric parser, utf-8 encoder, output
// ----------------------------------------------------------------------------
module xer_dp
    import xer_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output sts_t       sts,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       cfg_valid,
    input  logic       cfg_data,
    input  logic       out_tready,
    output logic       out_tvalid,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       out_unk
);

    logic [7:0]       buf_reg [BUF_DEPTH];
    logic [7:0]       buf_shift [BUF_DEPTH];
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] p_reg;
    logic             amp_reg;
    logic             last_reg;
    logic             strict_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CP_W-1:0]  v_reg;
    logic             got_reg;
    logic             hex_reg;
    logic [CP_W-1:0]  cp_reg;
    logic [1:0]       u_reg;
    logic             pend_v_reg;
    logic [7:0]       pend_byte_reg;
    logic             pend_unk_reg;
    logic             out_v_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    logic             out_unk_reg;

    logic [CNT_W:0]   src;
    logic [CNT_W-1:0] drop_n;
    logic [7:0]       cur;
    logic [7:0]       dig_c;
    logic             is_dig;
    logic [3:0]       dig;
    logic [ACC_W-1:0] acc_mul;
    logic [ACC_W-1:0] acc_next;
    logic             acc_ovf;
    logic             dig_avail;
    logic             tab_hit;
    logic [15:0]      tab_cp;
    logic             m;
    logic [1:0]       ulen;
    logic [7:0]       utf_byte;
    logic [7:0]       em_byte;
    logic             em_unk;
    logic             out_room;

    // window shift: drop the current byte and everything before it
    always_comb
    begin
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            src = (CNT_W+1)'(i) + {1'b0, p_reg} + (CNT_W+1)'(1);
            if (src < (CNT_W+1)'(BUF_DEPTH))
                buf_shift[i] = buf_reg[src[IDX_W-1:0]];
            else
                buf_shift[i] = buf_reg[i];
        end
    end

    assign drop_n = n_reg - p_reg - CNT_W'(1);
    assign cur    = buf_reg[p_reg[IDX_W-1:0]];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            buf_reg[n_reg[IDX_W-1:0]] <= in_byte;
        else if (cmd.drop)
            buf_reg <= buf_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg      <= '0;
            p_reg      <= '0;
            amp_reg    <= 1'b0;
            last_reg   <= 1'b0;
            strict_reg <= 1'b1;
        end
        else
        begin
            if (cfg_valid)
                strict_reg <= cfg_data;
            if (cmd.load)
            begin
                n_reg    <= n_reg + CNT_W'(1);
                last_reg <= in_last;
            end
            else if (cmd.drop)
                n_reg <= drop_n;
            if (cmd.drop || cmd.rewind)
                p_reg <= '0;
            else if (cmd.hold)
                p_reg <= p_reg + CNT_W'(1);
            if (cmd.amp_set)
                amp_reg <= 1'b1;
            else if (cmd.amp_clr)
                amp_reg <= 1'b0;
        end
    end

    // named entity match
    always_comb
    begin
        tab_hit = 1'b0;
        tab_cp  = '0;
        for (int k = 0; k < ENT_NUM; k++)
        begin
            m = (p_reg == CNT_W'(ENT_LEN[k]));
            for (int j = 0; j < NAME_MAX; j++)
            begin
                if (j < int'(ENT_LEN[k]))
                    m = m & (buf_reg[j] == ent_byte(k, j));
            end
            tab_hit = tab_hit | m;
            if (m)
                tab_cp = tab_cp | ENT_CP[k];
        end
    end

    // numeric reference, one digit per cycle
    assign dig_c = buf_reg[idx_reg[IDX_W-1:0]];

    always_comb
    begin
        is_dig = 1'b0;
        dig    = '0;
        if (dig_c >= "0" && dig_c <= "9")
        begin
            is_dig = 1'b1;
            dig    = 4'(dig_c - "0");
        end
        else if (hex_reg && dig_c >= "a" && dig_c <= "f")
        begin
            is_dig = 1'b1;
            dig    = 4'(dig_c - 8'h57);
        end
        else if (hex_reg && dig_c >= "A" && dig_c <= "F")
        begin
            is_dig = 1'b1;
            dig    = 4'(dig_c - 8'h37);
        end
    end

    assign acc_mul   = hex_reg ? {v_reg, 4'b0000}
                               : ({1'b0, v_reg, 3'b000} + {3'b000, v_reg, 1'b0});
    assign acc_next  = acc_mul + ACC_W'(dig);
    assign acc_ovf   = acc_next > ACC_W'(CP_MAX);
    assign dig_avail = (idx_reg < p_reg) && is_dig;

    always_ff @(posedge clk)
    begin
        if (cmd.parse_start)
        begin
            idx_reg <= (buf_reg[1] == CH_LOW_X || buf_reg[1] == CH_UP_X) ? CNT_W'(2)
                                                                       : CNT_W'(1);
            hex_reg <= (buf_reg[1] == CH_LOW_X || buf_reg[1] == CH_UP_X);
            v_reg   <= '0;
            got_reg <= 1'b0;
        end
        else if (cmd.parse_step)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
            v_reg   <= acc_next[CP_W-1:0];
            got_reg <= 1'b1;
        end
        if (cmd.tab_load)
            cp_reg <= CP_W'(tab_cp);
        else if (cmd.cp_num)
            cp_reg <= v_reg;
    end

    // utf-8 encoder
    assign ulen = (cp_reg < CP_W'(32'h80))    ? 2'd0 :
                  (cp_reg < CP_W'(32'h800))   ? 2'd1 :
                  (cp_reg < CP_W'(32'h10000)) ? 2'd2 : 2'd3;

    always_comb
    begin
        case (ulen)
            2'd0: utf_byte = cp_reg[7:0];
            2'd1: utf_byte = (u_reg == 2'd0) ? {3'b110, cp_reg[10:6]} : {2'b10, cp_reg[5:0]};
            2'd2:
            begin
                case (u_reg)
                    2'd0:    utf_byte = {4'b1110, cp_reg[15:12]};
                    2'd1:    utf_byte = {2'b10, cp_reg[11:6]};
                    default: utf_byte = {2'b10, cp_reg[5:0]};
                endcase
            end
            default:
            begin
                case (u_reg)
                    2'd0:    utf_byte = {5'b11110, cp_reg[20:18]};
                    2'd1:    utf_byte = {2'b10, cp_reg[17:12]};
                    2'd2:    utf_byte = {2'b10, cp_reg[11:6]};
                    default: utf_byte = {2'b10, cp_reg[5:0]};
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            u_reg <= '0;
        else if (cmd.tab_load || cmd.cp_num)
            u_reg <= '0;
        else if (cmd.utf_step)
            u_reg <= u_reg + 2'd1;
    end

    // output: one pending beat plus the output register
    always_comb
    begin
        case (cmd.emit_sel)
            SEL_CUR:     begin em_byte = cur;      em_unk = 1'b0;       end
            SEL_AMP:     begin em_byte = CH_AMP;   em_unk = 1'b0;       end
            SEL_AMP_UNK: begin em_byte = CH_AMP;   em_unk = strict_reg; end
            default:     begin em_byte = utf_byte; em_unk = 1'b0;       end
        endcase
    end

    assign out_room = !out_v_reg || out_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
                pend_v_reg <= 1'b1;
            else if (cmd.flush)
                pend_v_reg <= 1'b0;
            if ((cmd.emit || cmd.flush) && pend_v_reg)
                out_v_reg <= 1'b1;
            else if (out_tready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pend_byte_reg <= em_byte;
            pend_unk_reg  <= em_unk;
        end
        if ((cmd.emit || cmd.flush) && pend_v_reg)
        begin
            out_byte_reg <= pend_byte_reg;
            out_unk_reg  <= pend_unk_reg;
            out_last_reg <= cmd.flush & last_reg;
        end
    end

    assign out_tvalid = out_v_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;
    assign out_unk    = out_unk_reg;

    always_comb
    begin
        sts.have_byte   = p_reg < n_reg;
        sts.is_amp      = cur == CH_AMP;
        sts.is_semi     = cur == CH_SEMI;
        sts.window_full = p_reg >= CNT_W'(SCAN_WINDOW - 1);
        sts.amp_open    = amp_reg;
        sts.last        = last_reg;
        sts.tab_hit     = tab_hit;
        sts.numeric     = (p_reg >= CNT_W'(2)) && (buf_reg[0] == CH_HASH);
        sts.parse_more  = dig_avail && !acc_ovf;
        sts.parse_ok    = got_reg && (v_reg != '0) && !(dig_avail && acc_ovf);
        sts.utf_final   = u_reg == ulen;
        sts.can_emit    = !pend_v_reg || out_room;
        sts.can_flush   = !pend_v_reg || out_room;
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit || cmd.flush) && pend_v_reg |-> out_room)
        else $error("pending beat overwrites a stalled output");

    a_ptr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        p_reg <= n_reg && n_reg <= CNT_W'(BUF_DEPTH))
        else $error("scan pointer beyond window");

    a_closed_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !amp_reg |-> p_reg == '0)
        else $error("bytes held with no open reference");

endmodule

### bench/tb_xml_entity_reference_decoder.sv
// ----------------------------------------------------------------------------
// tb_xml_entity_reference_decoder
// self-checking bench for the xml entity reference decoder
// ----------------------------------------------------------------------------
// drives byte beats carrying named, numeric, malformed and overrun references
// mixed with noise, predicts the decoded byte stream beat by beat and compares
// every output beat in order, under three idling mixes and both strict modes
// ----------------------------------------------------------------------------
module tb_xml_entity_reference_decoder
    import xer_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       unk;
    } out_beat_t;

    class entity_scoreboard;
        out_beat_t  pending[$];
        logic [7:0] window[SCAN_WINDOW];
        int         held;
        bit         amp_open;
        bit         strict;
        int         errors;
        string      names[30] = '{"lt", "gt", "amp", "quot", "apos", "nbsp", "copy",
            "reg", "trade", "hellip", "ndash", "mdash", "lsquo", "rsquo", "ldquo",
            "rdquo", "laquo", "raquo", "middot", "bull", "sect", "para", "deg",
            "plusmn", "times", "divide", "euro", "pound", "yen", "cent"};
        int         points[30] = '{'h3C, 'h3E, 'h26, 'h22, 'h27, 'hA0, 'hA9, 'hAE,
            'h2122, 'h2026, 'h2013, 'h2014, 'h2018, 'h2019, 'h201C, 'h201D, 'hAB,
            'hBB, 'hB7, 'h2022, 'hA7, 'hB6, 'hB0, 'hB1, 'hD7, 'hF7, 'h20AC, 'hA3,
            'hA5, 'hA2};

        function new();
            held = 0;
            amp_open = 0;
            strict = 1;
            errors = 0;
        endfunction

        function void push(logic [7:0] b, logic unk);
            out_beat_t e;
            e.data = b;
            e.last = 0;
            e.unk = unk;
            pending.push_back(e);
        endfunction

        function void push_utf8(int cp);
            if (cp < 'h80)
                push(cp[7:0], 0);
            else if (cp < 'h800)
            begin
                push(8'hC0 | cp[10:6], 0);
                push(8'h80 | cp[5:0], 0);
            end
            else if (cp < 'h10000)
            begin
                push(8'hE0 | cp[15:12], 0);
                push(8'h80 | cp[11:6], 0);
                push(8'h80 | cp[5:0], 0);
            end
            else
            begin
                push(8'hF0 | cp[20:18], 0);
                push(8'h80 | cp[17:12], 0);
                push(8'h80 | cp[11:6], 0);
                push(8'h80 | cp[5:0], 0);
            end
        endfunction

        function int code_point();
            int         v;
            int         i;
            int         first;
            int         d;
            bit         hex;
            bit         same;
            logic [7:0] c;
            v = 0;
            foreach (names[k])
            begin
                if (names[k].len() == held)
                begin
                    same = 1;
                    for (int j = 0; j < held; j++)
                        if (window[j] != names[k][j])
                            same = 0;
                    if (same)
                        return points[k];
                end
            end
            if (held < 2 || window[0] != CH_HASH)
                return 0;
            hex = (window[1] == CH_LOW_X || window[1] == CH_UP_X);
            first = hex ? 2 : 1;
            for (i = first; i < held; i++)
            begin
                c = window[i];
                if (c >= "0" && c <= "9")
                    d = c - "0";
                else if (hex && c >= "a" && c <= "f")
                    d = c - "a" + 10;
                else if (hex && c >= "A" && c <= "F")
                    d = c - "A" + 10;
                else
                    break;
                v = v * (hex ? 16 : 10) + d;
                if (v > CP_MAX)
                    break;
            end
            if (i > first && v > 0 && v <= CP_MAX)
                return v;
            return 0;
        endfunction

        function void note_input(logic [7:0] in_byte, logic in_last);
            logic [7:0] work[$];
            logic [7:0] c;
            logic [7:0] rest[$];
            int         start;
            int         cp;
            bit         fail;
            bit         flag;
            start = pending.size();
            work.push_back(in_byte);
            forever
            begin
                while (work.size() > 0)
                begin
                    c = work.pop_front();
                    fail = 0;
                    flag = 0;
                    if (!amp_open)
                    begin
                        if (c == CH_AMP)
                        begin
                            amp_open = 1;
                            held = 0;
                        end
                        else
                            push(c, 0);
                        continue;
                    end
                    if (c == CH_SEMI)
                    begin
                        cp = code_point();
                        if (cp != 0)
                        begin
                            push_utf8(cp);
                            amp_open = 0;
                            held = 0;
                            continue;
                        end
                        fail = 1;
                        flag = strict;
                    end
                    else if (held + 1 >= SCAN_WINDOW)
                        fail = 1;
                    else
                    begin
                        window[held] = c;
                        held++;
                    end
                    if (fail)
                    begin
                        push(CH_AMP, flag);
                        rest = work;
                        work = {};
                        for (int k = 0; k < held; k++)
                            work.push_back(window[k]);
                        work.push_back(c);
                        foreach (rest[k])
                            if (work.size() < SCAN_WINDOW + 1)
                                work.push_back(rest[k]);
                        amp_open = 0;
                        held = 0;
                    end
                end
                if (!(in_last && amp_open))
                    break;
                push(CH_AMP, 0);
                for (int k = 0; k < held; k++)
                    work.push_back(window[k]);
                amp_open = 0;
                held = 0;
            end
            if (in_last && pending.size() > start)
                pending[pending.size() - 1].last = 1;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check(logic [7:0] data, logic last, logic unk);
            out_beat_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected beat %h", data));
                return;
            end
            e = pending.pop_front();
            if (data !== e.data)
                report($sformatf("tdata %h, want %h", data, e.data));
            if (last !== e.last)
                report($sformatf("tlast %b, want %b", last, e.last));
            if (unk !== e.unk)
                report($sformatf("tuser %b, want %b", unk, e.unk));
        endtask
    endclass

    logic       clk = 0;
    logic       rst_n = 0;
    logic       s_axis_tvalid = 0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 0;
    logic       s_axis_tlast = 0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic       m_axis_tuser;
    logic       cfg_valid = 0;
    logic       cfg_ready;
    logic       cfg_data = 0;

    entity_scoreboard decoded = new();
    int send_idle = 0;
    int recv_idle = 0;

    xml_entity_reference_decoder dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                decoded.note_input(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                decoded.check(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if (cfg_valid && cfg_ready)
                decoded.strict = cfg_data;
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        if ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_text(string s, logic last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last && (i == s.len() - 1));
    endtask

    task automatic write_strict(logic v);
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (decoded.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_valid <= 1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    function automatic string random_ref();
        string s;
        int    v;
        s = "&";
        case ($urandom_range(5))
            0, 1: s = {s, decoded.names[$urandom_range(29)]};
            2: s = {s, $sformatf("#%0d", $urandom_range(0, 'h11000))};
            3:
            begin
                v = $urandom_range(0, 'h110FFF);
                s = {s, $urandom_range(1) ? $sformatf("#x%0h", v) : $sformatf("#X%0H", v)};
            end
            4: s = {s, $sformatf("#%0dz", $urandom_range(1, 999))};
            default:
                repeat ($urandom_range(0, 13))
                    s = {s, string'(byte'($urandom_range(33, 126)))};
        endcase
        if ($urandom_range(9) != 0)
            s = {s, ";"};
        return s;
    endfunction

    task automatic random_phase(int count);
        int    n;
        string s;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(9) < 7)
                s = random_ref();
            else
            begin
                s = "";
                repeat ($urandom_range(1, 5))
                    s = {s, string'(byte'($urandom_range(255)))};
            end
            for (int i = 0; i < s.len(); i++)
            begin
                send_byte(s[i], (i == s.len() - 1) && ($urandom_range(14) == 0));
                n++;
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_text("&lt;&#x10FFFF;&;&#;", 0);
        send_text("&bogus;&abcdefghijklm", 0);
        send_text("&a&amp;&gt", 1);
        send_byte(8'h00, 0);
        send_byte(8'hFF, 1);
        write_strict(0);
        send_text("&#x;&#1114112;&q;", 1);
        send_idle = 15;
        recv_idle = 76;
        random_phase(130);
        write_strict(1);
        send_idle = 76;
        recv_idle = 15;
        random_phase(130);
        write_strict(0);
        send_idle = 0;
        recv_idle = 0;
        random_phase(130);
        s_axis_tvalid <= 0;
        while (decoded.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (decoded.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
hw/rtl/xer_pkg.sv
hw/rtl/xer_ctrl.sv
hw/rtl/xer_dp.sv
hw/rtl/xml_entity_reference_decoder.sv
bench/tb_xml_entity_reference_decoder.sv
